// ===== sv/tcd_pkg.sv =====
// shared types and constants for the ternary comma stream decoder
`default_nettype none
package tcd_pkg;

  localparam int WORD_BITS       = 64;
  localparam int VALUE_BITS      = 16;
  localparam int COUNT_BITS      = 32;
  localparam int SYMS_PER_WORD   = WORD_BITS / 2;
  localparam int SYM_IDX_BITS    = $clog2(SYMS_PER_WORD);
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_ADDR_BITS  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS   = FIFO_ADDR_BITS + 1;
  localparam int ENTRY_BITS      = WORD_BITS + 1;

  localparam logic [1:0] SYM_COMMA = 2'd3;

  typedef struct packed {
    logic pop;
    logic busy;
    logic loading;
  } dec_status_t;

  typedef struct packed {
    logic [FIFO_CNT_BITS-1:0] count;
    logic                     not_empty;
  } fifo_status_t;

endpackage
`default_nettype wire

// ===== sv/tcd_if.sv =====
// stream interfaces for packed words and decoded values
`default_nettype none
interface tcd_word_if;
  logic                           valid;
  logic                           ready;
  logic [tcd_pkg::WORD_BITS-1:0]  packed_word;
  logic                           final_word;

  modport source (output valid, output packed_word, output final_word, input ready);
  modport sink (input valid, input packed_word, input final_word, output ready);
endinterface

interface tcd_value_if;
  logic                           valid;
  logic                           ready;
  logic [tcd_pkg::VALUE_BITS-1:0] decoded_value;
  logic                           value_overflow;
  logic                           last_value;

  modport source (output valid, output decoded_value, output value_overflow,
                  output last_value, input ready);
  modport sink (input valid, input decoded_value, input value_overflow,
                input last_value, output ready);
endinterface
`default_nettype wire

// ===== sv/tcd_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module tcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/tcd_word_fifo.sv =====
// input word queue held in ram, pointers and fill count in flops
`default_nettype none
module tcd_word_fifo (
  input  wire logic                            clk,
  input  wire logic                            rst,
  tcd_word_if.sink                             words,
  input  wire tcd_pkg::dec_status_t            dec_status,
  output      tcd_pkg::fifo_status_t           fifo_status,
  output      logic [tcd_pkg::ENTRY_BITS-1:0]  rd_entry
);

  logic [tcd_pkg::FIFO_ADDR_BITS-1:0] wr_ptr;
  logic [tcd_pkg::FIFO_ADDR_BITS-1:0] rd_ptr;
  logic [tcd_pkg::FIFO_CNT_BITS-1:0]  count;
  logic                               push;
  logic                               pop;

  assign words.ready = (count != tcd_pkg::FIFO_CNT_BITS'(tcd_pkg::FIFO_DEPTH));
  assign push        = words.valid && words.ready;
  assign pop         = dec_status.pop;

  assign fifo_status.count     = count;
  assign fifo_status.not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  tcd_ram #(
    .WIDTH (tcd_pkg::ENTRY_BITS),
    .DEPTH (tcd_pkg::FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (wr_ptr),
    .wdata ({words.final_word, words.packed_word}),
    .re    (pop),
    .raddr (rd_ptr),
    .rdata (rd_entry)
  );

endmodule
`default_nettype wire

// ===== sv/tcd_symbol_decoder.sv =====
// walks one symbol per cycle unless a held result stalls it, builds values and registers each result
`default_nettype none
module tcd_symbol_decoder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [tcd_pkg::COUNT_BITS-1:0]  cfg_wdata,
  input  wire tcd_pkg::fifo_status_t           fifo_status,
  input  wire logic [tcd_pkg::ENTRY_BITS-1:0]  rd_entry,
  output      tcd_pkg::dec_status_t            dec_status,
  tcd_value_if.source                          values
);

  logic [tcd_pkg::COUNT_BITS-1:0]   value_count;
  logic [tcd_pkg::COUNT_BITS-1:0]   emitted_count;
  logic [tcd_pkg::COUNT_BITS-1:0]   emitted_inc;
  logic [tcd_pkg::VALUE_BITS-1:0]   partial_value;
  logic                             partial_overflow;
  logic [tcd_pkg::WORD_BITS-1:0]    word_sh;
  logic                             final_flag;
  logic [tcd_pkg::SYM_IDX_BITS-1:0] sym_idx;
  logic                             busy;
  logic                             loading;
  logic                             out_valid;
  logic [tcd_pkg::VALUE_BITS-1:0]   out_value;
  logic                             out_overflow;
  logic                             out_last;

  logic                             advance;
  logic                             pop;
  logic                             active;
  logic [1:0]                       sym;
  logic [tcd_pkg::VALUE_BITS+1:0]   wide;
  logic                             last_sym;
  logic                             emit;

  assign advance  = !out_valid || values.ready;
  assign pop      = !busy && !loading && fifo_status.not_empty;
  assign active   = (emitted_count < value_count);
  assign sym      = word_sh[1:0];
  // value*3 + digit + 1, two extra bits catch the overflow
  assign wide     = {1'b0, partial_value, 1'b0} + {2'b00, partial_value}
                  + {{tcd_pkg::VALUE_BITS{1'b0}}, sym}
                  + (tcd_pkg::VALUE_BITS+2)'(1);
  assign last_sym = (sym_idx == tcd_pkg::SYM_IDX_BITS'(tcd_pkg::SYMS_PER_WORD - 1));
  assign emitted_inc = emitted_count + 1'b1;
  assign emit     = busy && advance && active && (sym == tcd_pkg::SYM_COMMA);

  assign dec_status.pop     = pop;
  assign dec_status.busy    = busy;
  assign dec_status.loading = loading;

  assign values.valid          = out_valid;
  assign values.decoded_value  = out_value;
  assign values.value_overflow = out_overflow;
  assign values.last_value     = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_count      <= '0;
      emitted_count    <= '0;
      partial_value    <= '0;
      partial_overflow <= 1'b0;
      busy             <= 1'b0;
      loading          <= 1'b0;
      out_valid        <= 1'b0;
      sym_idx          <= '0;
    end else begin
      if (cfg_we) begin
        value_count <= cfg_wdata;
      end
      loading <= pop;
      if (loading) begin
        word_sh    <= rd_entry[tcd_pkg::WORD_BITS-1:0];
        final_flag <= rd_entry[tcd_pkg::WORD_BITS];
        sym_idx    <= '0;
        busy       <= 1'b1;
      end else if (busy && advance) begin
        word_sh <= word_sh >> 2;
        sym_idx <= sym_idx + 1'b1;
        if (last_sym) begin
          busy <= 1'b0;
        end
        // end of stream drops any open code and restarts the count
        if (last_sym && final_flag) begin
          emitted_count    <= '0;
          partial_value    <= '0;
          partial_overflow <= 1'b0;
        end else if (active) begin
          if (sym == tcd_pkg::SYM_COMMA) begin
            emitted_count    <= emitted_inc;
            partial_value    <= '0;
            partial_overflow <= 1'b0;
          end else begin
            partial_value <= wide[tcd_pkg::VALUE_BITS-1:0];
            if (wide[tcd_pkg::VALUE_BITS+1:tcd_pkg::VALUE_BITS] != 2'b00) begin
              partial_overflow <= 1'b1;
            end
          end
        end
      end
      // result register loads on a comma while the count is not reached, otherwise empties once taken
      if (emit) begin
        out_valid    <= 1'b1;
        out_value    <= partial_value;
        out_overflow <= partial_overflow;
        out_last     <= (emitted_inc == value_count);
      end else if (values.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/ternary_comma_stream_decoder_core.sv =====
// top level of the ternary comma stream decoder
//
// words channel: one 64-bit packed_word per transaction, 32 two-bit symbols
// taken from bit 0 upward; final_word marks the last word of a stream.
// values channel: one decoded value per transaction with its overflow flag,
// and last_value on the value that reaches the configured count.
// cfg_we/cfg_wdata write value_count; write it only while the block is idle.
// words go into a four-entry queue in ram, so up to four words are taken
// while earlier ones are still being decoded or a result waits.
// the decoder walks one symbol per cycle while no result is held back: a
// word is first read from the ram, then loaded, then its 32 symbols are
// walked; the next word is read only after the last symbol of this one.
// a comma's value passes the queue ram, the registered ram read, the word
// shift register and the result register before it reaches the values channel.
// when values.ready is low the result register holds and the decoder stops
// on the next symbol; the queue keeps taking words until it is full.
// reset (rst, synchronous) empties the queue, clears the open value, the
// emitted count and value_count; no clearing pass is needed.
`default_nettype none
module ternary_comma_stream_decoder_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [tcd_pkg::COUNT_BITS-1:0] cfg_wdata,
  tcd_word_if.sink                            words,
  tcd_value_if.source                         values
);

  tcd_pkg::dec_status_t           dec_status;
  tcd_pkg::fifo_status_t          fifo_status;
  logic [tcd_pkg::ENTRY_BITS-1:0] rd_entry;

  tcd_word_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .words       (words),
    .dec_status  (dec_status),
    .fifo_status (fifo_status),
    .rd_entry    (rd_entry)
  );

  tcd_symbol_decoder u_dec (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fifo_status (fifo_status),
    .rd_entry    (rd_entry),
    .dec_status  (dec_status),
    .values      (values)
  );

`ifndef ASSERT_OFF
  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    fifo_status.count <= tcd_pkg::FIFO_CNT_BITS'(tcd_pkg::FIFO_DEPTH))
    else $error("word queue fill count out of range");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    dec_status.pop |-> fifo_status.not_empty)
    else $error("word read from empty queue");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    dec_status.pop |=> dec_status.loading && !dec_status.busy)
    else $error("word load overlaps a word in progress");
`endif

endmodule
`default_nettype wire
